>>> rtl/core/rms_pkg.sv
// Shared types, constants and helpers for the rotor move supervisor.
package rms_pkg;

  localparam int unsigned TimeW     = 48;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned ErrW      = 15;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [AngleW-1:0] FullTurn = 16'd36000;
  localparam logic [AngleW-1:0] HalfTurn = 16'd18000;

  localparam logic [14:0] TolAzRst      = 15'd50;
  localparam logic [14:0] TolElRst      = 15'd50;
  localparam logic [15:0] MotionThrRst  = 16'd10;
  localparam logic [31:0] MoveIntvRst   = 32'd1000000;
  localparam logic [31:0] StallTmoRst   = 32'd5000000;
  localparam logic [31:0] PosTmoRst     = 32'd3000000;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TOL_AZ        = 3'd0,
    CFG_TOL_EL        = 3'd1,
    CFG_MOTION_THR    = 3'd2,
    CFG_MOVE_INTERVAL = 3'd3,
    CFG_STALL_TIMEOUT = 3'd4,
    CFG_POS_TIMEOUT   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                     cmd;
    logic [TimeW-1:0]         time_now;
    logic                     position_ok;
    logic [TimeW-1:0]         report_time;
    logic [AngleW-1:0]        meas_az;
    logic signed [AngleW-1:0] meas_el;
    logic [AngleW-1:0]        goal_az;
    logic signed [AngleW-1:0] goal_el;
  } req_t;

  typedef struct packed {
    logic [ErrW-1:0] error_az;
    logic [ErrW-1:0] error_el;
    logic            position_lost;
    logic            stalled;
    logic            move_now;
  } rsp_t;

  // Reduce a 16-bit azimuth into one turn; one subtract is enough below 65536.
  function automatic logic [AngleW-1:0] wrap_turn(input logic [AngleW-1:0] x);
    return (x >= FullTurn) ? (x - FullTurn) : x;
  endfunction

  // Magnitude of a 17-bit signed difference; fits 16 bits for 16-bit operands.
  function automatic logic [AngleW-1:0] abs_diff(input logic [AngleW:0] d);
    logic [AngleW:0] m;
    m = d[AngleW] ? (~d + 17'd1) : d;
    return m[AngleW-1:0];
  endfunction

  // True when a - b, taken as an exact signed difference, reaches lim.
  function automatic logic time_ge(input logic [TimeW-1:0] a,
                                   input logic [TimeW-1:0] b,
                                   input logic [CfgDataW-1:0] lim);
    logic [TimeW:0] d;
    d = {1'b0, a} - {1'b0, b};
    return !d[TimeW] && (d[TimeW-1:0] >= {{(TimeW-CfgDataW){1'b0}}, lim});
  endfunction

endpackage

>>> rtl/core/rms_if.sv
// Handshake channels of the rotor move supervisor: request, result and config write.
interface rms_req_if import rms_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rms_rsp_if import rms_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rms_cfg_if import rms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

>>> rtl/core/rotor_move_supervisor.sv
// Rotor move supervisor: errors, position-lost, stall and move decisions per word.
// Pipeline: an accepted word is taken into the input register s1_q; its result is registered
// in out_q and offered from there, and s1_q holds while out_q waits on the result side.
// Throughput: one word per cycle unless the result side stalls; the input register feeds
// the rotor state update directly. Config writes are always ready.
// Reset (rst_ni low, async): config registers take their defaults, rotor state clears,
// both pipeline registers empty.
module rotor_move_supervisor import rms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rms_req_if.sink   req_i,
  rms_rsp_if.source rsp_o,
  rms_cfg_if.sink   cfg_i
);

  // configuration
  logic [14:0] tol_az_q, tol_el_q;
  logic [15:0] motion_thr_q;
  logic [31:0] move_intv_q, stall_tmo_q, pos_tmo_q;

  // rotor state
  logic                     have_prev_q;
  logic [AngleW-1:0]        prev_az_q;
  logic signed [AngleW-1:0] prev_el_q;
  logic [TimeW-1:0]         change_time_q;
  logic [TimeW-1:0]         move_time_q;

  // pipeline
  logic s1_valid_q, out_valid_q;
  req_t s1_q;
  rsp_t out_q, out_d;
  logic s1_adv;

  // datapath
  logic [AngleW-1:0] g_az, m_az, d_az, e_az;
  logic [AngleW:0]   d_raw;
  logic [AngleW-1:0] e_el;
  logic              off, moved_az, moved_el, changed;
  logic              mv_set, lost, stall, moved, move;

  assign cfg_i.ready = 1'b1;

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    g_az  = wrap_turn(s1_q.goal_az);
    m_az  = wrap_turn(s1_q.meas_az);
    d_raw = {1'b0, g_az} + {1'b0, FullTurn} - {1'b0, m_az};
    d_az  = (d_raw >= {1'b0, FullTurn}) ? (d_raw[AngleW-1:0] - FullTurn) : d_raw[AngleW-1:0];
    e_az  = (d_az > HalfTurn) ? (FullTurn - d_az) : d_az;
    e_el  = abs_diff({s1_q.meas_el[AngleW-1], s1_q.meas_el}
                     - {s1_q.goal_el[AngleW-1], s1_q.goal_el});

    off = (e_az > {1'b0, tol_az_q}) || (e_el > {1'b0, tol_el_q});

    moved_az = abs_diff({1'b0, s1_q.meas_az} - {1'b0, prev_az_q}) >= motion_thr_q;
    moved_el = abs_diff({s1_q.meas_el[AngleW-1], s1_q.meas_el}
                        - {prev_el_q[AngleW-1], prev_el_q}) >= motion_thr_q;
    changed  = s1_q.position_ok && (!have_prev_q || moved_az || moved_el);

    mv_set = (move_time_q != '0);

    lost = (pos_tmo_q != '0) &&
           (!s1_q.position_ok || (s1_q.report_time == '0) ||
            time_ge(s1_q.time_now, s1_q.report_time, pos_tmo_q));

    // a fresh change resets the quiet time to zero, which never reaches a nonzero timeout
    stall = s1_q.position_ok && mv_set && (stall_tmo_q != '0) && off && !changed &&
            time_ge(s1_q.time_now, move_time_q, stall_tmo_q) &&
            time_ge(s1_q.time_now, change_time_q, stall_tmo_q);

    moved = !mv_set || (changed ? (s1_q.time_now >= move_time_q)
                                : (change_time_q >= move_time_q));
    move  = !lost && !stall && off && moved &&
            (!mv_set || time_ge(s1_q.time_now, move_time_q, move_intv_q));

    out_d.error_az      = e_az[ErrW-1:0];
    out_d.error_el      = e_el[AngleW-1] ? {ErrW{1'b1}} : e_el[ErrW-1:0];
    out_d.position_lost = !s1_q.cmd && lost;
    out_d.stalled       = !s1_q.cmd && stall;
    out_d.move_now      = !s1_q.cmd && move;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_az_q     <= TolAzRst;
      tol_el_q     <= TolElRst;
      motion_thr_q <= MotionThrRst;
      move_intv_q  <= MoveIntvRst;
      stall_tmo_q  <= StallTmoRst;
      pos_tmo_q    <= PosTmoRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.addr))
        CFG_TOL_AZ:        tol_az_q     <= cfg_i.wdata[14:0];
        CFG_TOL_EL:        tol_el_q     <= cfg_i.wdata[14:0];
        CFG_MOTION_THR:    motion_thr_q <= cfg_i.wdata[15:0];
        CFG_MOVE_INTERVAL: move_intv_q  <= cfg_i.wdata;
        CFG_STALL_TIMEOUT: stall_tmo_q  <= cfg_i.wdata;
        CFG_POS_TIMEOUT:   pos_tmo_q    <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q   <= 1'b0;
      prev_az_q     <= '0;
      prev_el_q     <= '0;
      change_time_q <= '0;
      move_time_q   <= '0;
    end else if (s1_adv) begin
      if (s1_q.cmd) begin
        // re-arm from this word
        have_prev_q   <= s1_q.position_ok;
        prev_az_q     <= s1_q.meas_az;
        prev_el_q     <= s1_q.meas_el;
        change_time_q <= s1_q.time_now;
        move_time_q   <= '0;
      end else begin
        if (s1_q.position_ok) begin
          have_prev_q <= 1'b1;
          prev_az_q   <= s1_q.meas_az;
          prev_el_q   <= s1_q.meas_el;
        end
        if (changed) begin
          change_time_q <= s1_q.time_now;
        end
        if (move) begin
          move_time_q <= s1_q.time_now;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q <= req_i.data;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

endmodule

>>> sim/rms_result_check.sv
// Watches the rotor supervisor channels, predicts every result word and compares it.
module rms_result_check import rms_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  req_t                req_data_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  rsp_t                rsp_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  // rotor history as the block should hold it
  logic   have_prev;
  int     prev_az;
  int     prev_el;
  longint change_time;
  longint move_time;

  int     tol_az;
  int     tol_el;
  int     motion_thr;
  longint move_intv;
  longint stall_tmo;
  longint pos_tmo;

  rsp_t        expected_words[$];
  int unsigned fails;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fails++;
  endtask

  // Compute the result of one word and advance the rotor history.
  function automatic rsp_t supervise_word(input req_t w);
    int     maz;
    int     mel;
    int     gaz;
    int     gel;
    int     d;
    int     eaz;
    int     eel;
    longint now_us;
    longint rep_us;
    logic   off;
    logic   lost;
    logic   stall;
    logic   moved;
    rsp_t   r;
    maz = int'(w.meas_az);
    gaz = int'(w.goal_az);
    mel = int'($signed(w.meas_el));
    gel = int'($signed(w.goal_el));
    now_us = longint'(w.time_now);
    rep_us = longint'(w.report_time);
    // shortest way around, both angles folded into one turn first
    d = ((gaz % 36000) - (maz % 36000) + 36000) % 36000;
    eaz = (d > 18000) ? 36000 - d : d;
    eel = (mel > gel) ? mel - gel : gel - mel;
    lost = 1'b0;
    stall = 1'b0;
    r = '0;
    if (w.cmd) begin
      have_prev = w.position_ok;
      prev_az = maz;
      prev_el = mel;
      change_time = now_us;
      move_time = 0;
    end else begin
      off = (eaz > tol_az) || (eel > tol_el);
      if (w.position_ok) begin
        if (!have_prev ||
            ((maz > prev_az) ? maz - prev_az : prev_az - maz) >= motion_thr ||
            ((mel > prev_el) ? mel - prev_el : prev_el - mel) >= motion_thr)
          change_time = now_us;
        have_prev = 1'b1;
        prev_az = maz;
        prev_el = mel;
      end
      if (pos_tmo > 0 && (!w.position_ok || rep_us == 0 ||
                          (now_us > rep_us && now_us - rep_us >= pos_tmo)))
        lost = 1'b1;
      if (w.position_ok && move_time > 0 && stall_tmo > 0 &&
          now_us - move_time >= stall_tmo && now_us - change_time >= stall_tmo && off)
        stall = 1'b1;
      if (!lost && !stall) begin
        moved = (move_time == 0) || (change_time >= move_time);
        if (off && moved && (move_time == 0 || now_us - move_time >= move_intv)) begin
          r.move_now = 1'b1;
          move_time = now_us;
        end
      end
    end
    r.error_az = ErrW'(eaz);
    r.error_el = ErrW'((eel > 32767) ? 32767 : eel);
    r.position_lost = lost;
    r.stalled = stall;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      have_prev = 1'b0;
      prev_az = 0;
      prev_el = 0;
      change_time = 0;
      move_time = 0;
      tol_az = int'(TolAzRst);
      tol_el = int'(TolElRst);
      motion_thr = int'(MotionThrRst);
      move_intv = longint'(MoveIntvRst);
      stall_tmo = longint'(StallTmoRst);
      pos_tmo = longint'(PosTmoRst);
      expected_words.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // a result never leaves at the edge its word is accepted, so check before predicting
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with no word pending");
        end else begin
          want = expected_words.pop_front();
          if (rsp_data_i.error_az !== want.error_az)
            report_mismatch($sformatf("error_az got %0d want %0d",
                                      rsp_data_i.error_az, want.error_az));
          if (rsp_data_i.error_el !== want.error_el)
            report_mismatch($sformatf("error_el got %0d want %0d",
                                      rsp_data_i.error_el, want.error_el));
          if (rsp_data_i.position_lost !== want.position_lost)
            report_mismatch($sformatf("position_lost got %b want %b",
                                      rsp_data_i.position_lost, want.position_lost));
          if (rsp_data_i.stalled !== want.stalled)
            report_mismatch($sformatf("stalled got %b want %b",
                                      rsp_data_i.stalled, want.stalled));
          if (rsp_data_i.move_now !== want.move_now)
            report_mismatch($sformatf("move_now got %b want %b",
                                      rsp_data_i.move_now, want.move_now));
        end
      end
      if (req_valid_i && req_ready_i)
        expected_words.push_back(supervise_word(req_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          CFG_TOL_AZ:        tol_az = int'(cfg_wdata_i[14:0]);
          CFG_TOL_EL:        tol_el = int'(cfg_wdata_i[14:0]);
          CFG_MOTION_THR:    motion_thr = int'(cfg_wdata_i[15:0]);
          CFG_MOVE_INTERVAL: move_intv = longint'(cfg_wdata_i);
          CFG_STALL_TIMEOUT: stall_tmo = longint'(cfg_wdata_i);
          CFG_POS_TIMEOUT:   pos_tmo = longint'(cfg_wdata_i);
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o <= expected_words.size();
    end
  end

endmodule

>>> sim/testbench.sv
// Top of the rotor supervisor bench: clock, reset, stimulus, stall pressure and verdict.
module testbench;
  import rms_pkg::*;

  localparam int StuckLimit = 4000;

  logic clk = 1'b0;
  logic rst_n;

  rms_req_if req_ch ();
  rms_rsp_if rsp_ch ();
  rms_cfg_if cfg_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent;
  logic        no_idle;
  logic [47:0] clock_us;
  longint      span;
  int          stuck;

  rotor_move_supervisor dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  rms_result_check result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_ch.valid),
    .req_ready_i  (req_ch.ready),
    .req_data_i   (req_ch.data),
    .rsp_valid_i  (rsp_ch.valid),
    .rsp_ready_i  (rsp_ch.ready),
    .rsp_data_i   (rsp_ch.data),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_addr_i   (cfg_ch.addr),
    .cfg_wdata_i  (cfg_ch.wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stuck = 0;
    else
      stuck++;
    if (stuck >= StuckLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic req_t mk_word(input logic cmd, input logic [47:0] now, input logic ok,
                                   input logic [47:0] rep, input int maz, mel, gaz, gel);
    req_t w;
    w.cmd = cmd;
    w.time_now = now;
    w.position_ok = ok;
    w.report_time = rep;
    w.meas_az = 16'(maz);
    w.meas_el = 16'(mel);
    w.goal_az = 16'(gaz);
    w.goal_el = 16'(gel);
    return w;
  endfunction

  function automatic logic [47:0] rand_upto(input longint lim);
    longint unsigned r;
    r = {$urandom, $urandom};
    return 48'(r % (longint'(lim) + 1));
  endfunction

  function automatic int toward(input int cur, input int goal);
    int s;
    s = $urandom_range(0, 3000);
    if (cur < goal)
      return (goal - cur < s) ? goal : cur + s;
    return (cur - goal < s) ? goal : cur - s;
  endfunction

  function automatic logic [31:0] random_interval();
    if ($urandom_range(0, 5) == 0)
      return 32'd0;
    return $urandom >> $urandom_range(8, 31);
  endfunction

  task automatic send_word(input req_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= w;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    items_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
  endtask

  task automatic apply_settings(input int taz, input int tel, input int thr,
                                input logic [31:0] mi, input logic [31:0] sto,
                                input logic [31:0] pto);
    write_reg(CFG_TOL_AZ, 32'(taz));
    write_reg(CFG_TOL_EL, 32'(tel));
    write_reg(CFG_MOTION_THR, 32'(thr));
    write_reg(CFG_MOVE_INTERVAL, mi);
    write_reg(CFG_STALL_TIMEOUT, sto);
    write_reg(CFG_POS_TIMEOUT, pto);
    cfg_ch.valid <= 1'b0;
    span = (longint'(mi) + longint'(sto) + longint'(pto)) / 2 + 64;
  endtask

  // Hold the input idle until every predicted word has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // One tracking run: re-arm, then ticks with a rotor that moves, sticks or jumps and a goal that changes.
  task automatic run_session(input int n);
    req_t        w;
    int          i;
    int          r;
    int          az;
    int          el;
    int          gaz;
    int          gel;
    logic [47:0] age;
    logic [47:0] rep;
    no_idle <= ($urandom_range(0, 3) == 0);
    gaz = $urandom_range(0, 35999);
    gel = $urandom_range(0, 27000) - 9000;
    az = $urandom_range(0, 35999);
    el = $urandom_range(0, 27000) - 9000;
    send_word(mk_word(1'b1, clock_us, $urandom_range(0, 7) != 0, clock_us, az, el, gaz, gel));
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        clock_us = 48'({$urandom, $urandom});
      else if (r == 1)
        clock_us = clock_us - rand_upto(span);
      else
        clock_us = clock_us + rand_upto(span);
      r = $urandom_range(0, 9);
      if (r < 4) begin
        az = toward(az, gaz);
        el = toward(el, gel);
      end else if (r == 7) begin
        az = az + $urandom_range(0, 6) - 3;
        el = el + $urandom_range(0, 6) - 3;
        if (az < 0) az = 0;
        if (az > 35999) az = 35999;
      end else if (r == 8) begin
        az = $urandom_range(0, 35999);
        el = $urandom_range(0, 27000) - 9000;
      end else if (r == 9) begin
        gaz = $urandom_range(0, 35999);
        gel = $urandom_range(0, 27000) - 9000;
      end
      r = $urandom_range(0, 9);
      if (r < 7) begin
        age = rand_upto(span);
        rep = (clock_us > age) ? clock_us - age : 48'd1;
      end else if (r == 7) begin
        rep = '0;
      end else if (r == 8) begin
        rep = clock_us + 48'($urandom_range(1, 1000));
      end else begin
        rep = clock_us;
      end
      r = $urandom_range(0, 39);
      if (r == 0) begin
        // noise: every field drawn over its full width
        w.cmd = 1'($urandom);
        w.time_now = 48'({$urandom, $urandom});
        w.position_ok = 1'($urandom);
        w.report_time = 48'({$urandom, $urandom});
        w.meas_az = 16'($urandom);
        w.meas_el = 16'($urandom);
        w.goal_az = 16'($urandom);
        w.goal_el = 16'($urandom);
      end else begin
        w = mk_word(r == 1, clock_us, $urandom_range(0, 9) != 0, rep, az, el, gaz, gel);
      end
      send_word(w);
    end
  endtask

  task automatic fill_random(input int target);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < target)
      run_session($urandom_range(10, 60));
  endtask

  // Result side: random stalls, one long hold-off to back the block up.
  initial begin
    int unsigned n;
    int unsigned seen;
    seen = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 9);
      if (seen == 400)
        n = 300;
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      seen++;
    end
  end

  initial begin
    items_sent = 0;
    clock_us = '0;
    span = 3000000;
    no_idle <= 1'b0;
    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr <= '0;
    cfg_ch.wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset settings
    send_word(mk_word(1'b1, 48'd0, 1'b1, 48'd0, 0, 0, 0, 0));
    send_word(mk_word(1'b0, 48'd0, 1'b1, 48'd0, 0, 0, 0, 0));
    // move at time zero, then again since a zero move time still means never moved
    send_word(mk_word(1'b0, 48'd0, 1'b1, 48'd5, 0, 0, 18000, 0));
    send_word(mk_word(1'b0, 48'd5, 1'b1, 48'd5, 0, 0, 18000, 0));
    send_word(mk_word(1'b0, 48'd6, 1'b1, 48'd5, 35999, 18000, 0, -9000));
    // azimuth beyond one turn, elevation error past the field range
    send_word(mk_word(1'b0, 48'd7, 1'b1, 48'd6, 65535, -32768, 35999, 32767));
    send_word(mk_word(1'b0, 48'd8, 1'b1, 48'd7, 36000, 0, 65535, 0));
    send_word(mk_word(1'b0, 48'd9, 1'b0, 48'd8, 100, 100, 100, 100));
    send_word(mk_word(1'b0, 48'd4000000, 1'b1, 48'd500000, 100, 100, 200, 200));
    send_word(mk_word(1'b0, 48'd4000001, 1'b1, 48'd5000000, 100, 100, 200, 200));
    // move, stall while stuck, move once it turns, then hold off by interval
    send_word(mk_word(1'b1, 48'd1000000, 1'b1, 48'd1000000, 1000, 100, 5000, 2000));
    send_word(mk_word(1'b0, 48'd1500000, 1'b1, 48'd1499000, 1000, 100, 5000, 2000));
    send_word(mk_word(1'b0, 48'd7000000, 1'b1, 48'd6999999, 1000, 100, 5000, 2000));
    send_word(mk_word(1'b0, 48'd7100000, 1'b1, 48'd7099999, 1500, 300, 5000, 2000));
    send_word(mk_word(1'b0, 48'd7200000, 1'b1, 48'd7199999, 2000, 400, 5000, 2000));
    send_word(mk_word(1'b0, 48'd7300000, 1'b1, 48'd7299999, 5000, 2000, 5000, 2000));
    send_word(mk_word(1'b1, '1, 1'b0, '1, 65535, -1, 65535, -1));
    send_word(mk_word(1'b0, '1, 1'b1, 48'hFFFF_FFFF_FFFE, 0, -9000, 35999, 18000));
    // time running backward
    send_word(mk_word(1'b0, 48'd0, 1'b1, 48'd1, 0, 0, 20000, 100));
    send_word(mk_word(1'b1, 48'd2000, 1'b1, 48'd2000, 0, 0, 0, 0));
    clock_us = 48'd10000;
    fill_random(200);
    drain();

    apply_settings(0, 0, 0, '0, '0, '0);
    fill_random(220);
    drain();

    apply_settings(18000, 27000, 36000, '1, '1, '1);
    fill_random(200);
    drain();

    apply_settings(100, 100, 20, 32'd100, 32'd400, 32'd300);
    fill_random(250);
    drain();

    repeat (2) begin
      apply_settings($urandom_range(0, 18000), $urandom_range(0, 27000),
                     ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200)
                                                 : $urandom_range(0, 36000),
                     random_interval(), random_interval(), random_interval());
      fill_random(200);
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
